@@ rtl/core/tpfrt_pkg.sv @@
// package with widths, codes and helper functions of the three point frame realign block
`default_nettype none

package tpfrt_pkg;

   localparam int CW     = 32;          // coordinate width, signed q16.16
   localparam int QW     = 32;          // axis and rotation width, signed q2.30
   localparam int MAG_W  = 62;          // magnitude of a cross product component
   localparam int REQ_W  = 9 * CW;
   localparam int RSP_W  = 9 * QW + 3 * CW;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [QW-1:0] q30_type;

   localparam q30_type ONE_Q30 = 32'sh4000_0000;

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LOAD     = 4'd1;
   localparam logic [3:0] S_MUL      = 4'd2;
   localparam logic [3:0] S_ACC      = 4'd3;
   localparam logic [3:0] S_NCHK     = 4'd4;
   localparam logic [3:0] S_NSHIFT   = 4'd5;
   localparam logic [3:0] S_SQRT     = 4'd6;
   localparam logic [3:0] S_DIV_INIT = 4'd7;
   localparam logic [3:0] S_DIV      = 4'd8;
   localparam logic [3:0] S_FRAME    = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   // what the multiply-accumulate unit is working on
   localparam logic [1:0] C_CROSS = 2'd0;
   localparam logic [1:0] C_SQ    = 2'd1;
   localparam logic [1:0] C_ROT   = 2'd2;
   localparam logic [1:0] C_SHIFT = 2'd3;

   // frame build phases: which axis is being normalized
   localparam logic [1:0] PH_X = 2'd0;
   localparam logic [1:0] PH_T = 2'd1;
   localparam logic [1:0] PH_Y = 2'd2;
   localparam logic [1:0] PH_Z = 2'd3;

   localparam logic KIND_REF = 1'b0;

   function automatic logic [1:0] nxt3(input logic [1:0] i);
      case (i)
         2'd0:    nxt3 = 2'd1;
         2'd1:    nxt3 = 2'd2;
         default: nxt3 = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] prv3(input logic [1:0] i);
      case (i)
         2'd0:    prv3 = 2'd2;
         2'd1:    prv3 = 2'd0;
         default: prv3 = 2'd1;
      endcase
   endfunction

   function automatic logic [1:0] rot_row(input logic [3:0] i);
      case (i)
         4'd0, 4'd1, 4'd2: rot_row = 2'd0;
         4'd3, 4'd4, 4'd5: rot_row = 2'd1;
         default:          rot_row = 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] rot_col(input logic [3:0] i);
      case (i)
         4'd0, 4'd3, 4'd6: rot_col = 2'd0;
         4'd1, 4'd4, 4'd7: rot_col = 2'd1;
         default:          rot_col = 2'd2;
      endcase
   endfunction

   // round half up of v / 2^30
   function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sh2000_0000;
      rnd30 = t[63:30];
   endfunction

   function automatic q30_type sat_q30(input logic signed [33:0] v);
      if (v > 34'sh0_4000_0000)
         sat_q30 = ONE_Q30;
      else if (v < -34'sh0_4000_0000)
         sat_q30 = -ONE_Q30;
      else
         sat_q30 = v[QW-1:0];
   endfunction

   function automatic coord_type sat_coord(input logic signed [34:0] v);
      if (v > 35'sh0_7FFF_FFFF)
         sat_coord = 32'sh7FFF_FFFF;
      else if (v < -35'sh0_8000_0000)
         sat_coord = 32'sh8000_0000;
      else
         sat_coord = v[CW-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/three_point_frame_realign_transform_top.sv @@
// top level of the three point frame realign block: sequencer, shared mac and subtractor
`default_nettype none

// Three point frame realignment. Each request word carries three points p0, p1, p2 in
// signed q16.16 and a kind bit in tuser. The block builds an orthonormal frame from them
// (origin p0, x along p1-p0, y = unit(x cross unit(p2-p0)), z = unit(x cross y)); a
// degenerate set of points gives the identity axes. Kind 0 stores the frame as the
// reference and produces no response. Kind 1 builds the frame of the new points and
// returns one response word: the 3x3 rotation in q2.30 (saturated to +-1.0) and the
// saturated q16.16 shift that carry the reference frame onto the new one. A kind 1
// word before any reference word is dropped. Work is done one word at a time by one
// 32x32 multiplier with a 64-bit accumulator and one 64-bit subtractor under a small
// sequencer: each normalization takes up to 32 shift steps, 32 square root steps
// and three 31-step divisions, each division with its set-up state, and each product
// passes through the S_MUL and S_ACC states. The bit-serial square root and divider
// take most of the time a word occupies the block, which is far shorter for a
// degenerate point set; req_tready is high only between words. A finished response
// sits in the output register while the next request word is accepted.
module three_point_frame_realign_transform_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z from bit 0 up
   input  logic [tpfrt_pkg::REQ_W-1:0]  req_tdata,
   // kind
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // m_r0c0 .. m_r2c2 row by row, then shift_x, shift_y, shift_z from bit 0 up
   output logic [tpfrt_pkg::RSP_W-1:0]  rsp_tdata
);
   import tpfrt_pkg::*;

   // sequencer
   logic [3:0]  state_ff, state_in;
   logic [1:0]  ctx_ff, ctx_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  term_ff, term_in;
   logic [3:0]  res_ff, res_in;
   logic [4:0]  it_ff, it_in;
   logic [1:0]  comp_ff, comp_in;

   // captured request word
   logic        kind_ff, kind_in;
   coord_type   p_ff [9];
   coord_type   p_in [9];

   // vector being normalized
   logic [MAG_W-1:0] mag_ff [3];
   logic [MAG_W-1:0] mag_in [3];
   logic [2:0]  neg_ff, neg_in;

   // new frame axes (za holds the unit p2-p0 until z is written)
   q30_type     xa_ff [3], ya_ff [3], za_ff [3];
   q30_type     xa_in [3], ya_in [3], za_in [3];

   // reference frame
   q30_type     rx_ff [3], ry_ff [3], rz_ff [3];
   q30_type     rx_in [3], ry_in [3], rz_in [3];
   coord_type   org_ff [3];
   coord_type   org_in [3];
   logic        ref_valid_ff, ref_valid_in;

   // shared mac
   logic signed [63:0] prod_ff, acc_ff, acc_in;
   logic signed [31:0] mul_a, mul_b;

   // square root and divider registers
   logic [63:0] sx_ff, sx_in, root_ff, root_in;
   logic [30:0] len_ff, len_in, rem_ff, rem_in, num_ff, num_in, q_ff, q_in;

   // shared subtractor
   logic [63:0] sub_a, sub_b;
   logic [64:0] sub_d;
   logic        sub_ge;

   // results
   q30_type     rot_ff [9];
   q30_type     rot_in [9];
   coord_type   sh_ff [3];
   coord_type   sh_in [3];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // operand select for the shared multiplier
   always_comb begin
      logic [1:0] ia, ib, rr, cc;
      logic [3:0] ridx;
      ia = nxt3(res_ff[1:0]);
      ib = prv3(res_ff[1:0]);
      rr = rot_row(res_ff);
      cc = rot_col(res_ff);
      ridx = {res_ff[1:0], 1'b0} + {2'b0, res_ff[1:0]} + {2'b0, term_ff};
      mul_a = '0;
      mul_b = '0;
      case (ctx_ff)
         C_CROSS: begin
            // o[i] = a[i+1]*b[i+2] - a[i+2]*b[i+1]
            if (term_ff != 2'd0) begin
               ia = prv3(res_ff[1:0]);
               ib = nxt3(res_ff[1:0]);
            end
            mul_a = xa_ff[ia];
            mul_b = (phase_ff == PH_Z) ? ya_ff[ib] : za_ff[ib];
         end
         C_SQ: begin
            mul_a = {2'b00, mag_ff[term_ff][29:0]};
            mul_b = {2'b00, mag_ff[term_ff][29:0]};
         end
         C_ROT: begin
            case (term_ff)
               2'd0: begin
                  mul_a = xa_ff[rr];
                  mul_b = rx_ff[cc];
               end
               2'd1: begin
                  mul_a = ya_ff[rr];
                  mul_b = ry_ff[cc];
               end
               default: begin
                  mul_a = za_ff[rr];
                  mul_b = rz_ff[cc];
               end
            endcase
         end
         default: begin
            mul_a = rot_ff[ridx];
            mul_b = org_ff[term_ff];
         end
      endcase
   end

   // operand select for the shared subtractor
   always_comb begin
      if (state_ff == S_SQRT) begin
         sub_a = sx_ff;
         sub_b = root_ff + (64'd1 << {it_ff, 1'b0});
      end else begin
         sub_a = {32'd0, rem_ff, num_ff[30]};
         sub_b = {33'd0, len_ff};
      end
      sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
      sub_ge = ~sub_d[64];
   end

   // sequencer next state and datapath
   always_comb begin
      logic               last_term;
      logic               is_sub;
      logic signed [63:0] absv;
      logic signed [32:0] dv;
      logic               any_big, all_small, all_zero;
      logic [60:0]        nfull;
      q30_type            qv;
      logic signed [33:0] ro;
      logic [1:0]         src;

      state_in = state_ff;  ctx_in = ctx_ff;  phase_in = phase_ff;
      term_in = term_ff;    res_in = res_ff;  it_in = it_ff;  comp_in = comp_ff;
      kind_in = kind_ff;    neg_in = neg_ff;  ref_valid_in = ref_valid_ff;
      sx_in = sx_ff;  root_in = root_ff;  len_in = len_ff;
      rem_in = rem_ff;  num_in = num_ff;  q_in = q_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_data_in = rsp_data_ff;
      p_in = p_ff;  mag_in = mag_ff;
      xa_in = xa_ff;  ya_in = ya_ff;  za_in = za_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  rz_in = rz_ff;  org_in = org_ff;
      rot_in = rot_ff;  sh_in = sh_ff;

      last_term = (ctx_ff == C_CROSS) ? (term_ff == 2'd1) : (term_ff == 2'd2);
      is_sub    = (ctx_ff == C_CROSS) && (term_ff == 2'd1);
      acc_in    = ((term_ff == 2'd0) ? 64'sd0 : acc_ff) + (is_sub ? -prod_ff : prod_ff);
      absv      = acc_in[63] ? -acc_in : acc_in;
      ro        = rnd30(acc_in);

      any_big   = 1'b0;
      all_small = 1'b1;
      all_zero  = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (mag_ff[i][MAG_W-1:30] != '0) any_big = 1'b1;
         if (mag_ff[i][MAG_W-1:29] != '0) all_small = 1'b0;
         if (mag_ff[i] != '0) all_zero = 1'b0;
      end

      nfull = {1'b0, mag_ff[comp_ff][29:0], 30'd0} + {30'd0, 1'b0, len_ff[30:1]};
      qv = {1'b0, q_in};
      src = (phase_ff == PH_X) ? 2'd1 : 2'd2;

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               // a compute word before any reference is dropped
               if (req_tuser == KIND_REF || ref_valid_ff) begin
                  kind_in  = req_tuser;
                  for (int i = 0; i < 9; i++)
                     p_in[i] = req_tdata[CW*i +: CW];
                  phase_in = PH_X;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            if (phase_ff == PH_X || phase_ff == PH_T) begin
               for (int i = 0; i < 3; i++) begin
                  dv = {p_ff[3*src+i][CW-1], p_ff[3*src+i]} - {p_ff[i][CW-1], p_ff[i]};
                  neg_in[i] = dv[32];
                  mag_in[i] = MAG_W'(dv[32] ? -dv : dv);
               end
               state_in = S_NCHK;
            end else begin
               ctx_in   = C_CROSS;
               term_in  = 2'd0;
               res_in   = 4'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if (!last_term) begin
               term_in  = term_ff + 2'd1;
               state_in = S_MUL;
            end else begin
               term_in = 2'd0;
               case (ctx_ff)
                  C_CROSS: begin
                     mag_in[res_ff[1:0]] = absv[MAG_W-1:0];
                     neg_in[res_ff[1:0]] = acc_in[63];
                     if (res_ff == 4'd2) begin
                        res_in   = 4'd0;
                        state_in = S_NCHK;
                     end else begin
                        res_in   = res_ff + 4'd1;
                        state_in = S_MUL;
                     end
                  end
                  C_SQ: begin
                     sx_in    = acc_in;
                     root_in  = '0;
                     it_in    = 5'd31;
                     state_in = S_SQRT;
                  end
                  C_ROT: begin
                     rot_in[res_ff] = sat_q30(ro);
                     state_in = S_MUL;
                     if (res_ff == 4'd8) begin
                        res_in = 4'd0;
                        ctx_in = C_SHIFT;
                     end else begin
                        res_in = res_ff + 4'd1;
                     end
                  end
                  default: begin
                     sh_in[res_ff[1:0]] =
                        sat_coord(35'(p_ff[res_ff[1:0]]) - 35'(ro));
                     if (res_ff == 4'd2) begin
                        res_in   = 4'd0;
                        state_in = S_DONE;
                     end else begin
                        res_in   = res_ff + 4'd1;
                        state_in = S_MUL;
                     end
                  end
               endcase
            end
         end
         S_NCHK: begin
            if (all_zero) begin
               // degenerate points: identity axes
               xa_in[0] = ONE_Q30;  xa_in[1] = '0;       xa_in[2] = '0;
               ya_in[0] = '0;       ya_in[1] = ONE_Q30;  ya_in[2] = '0;
               za_in[0] = '0;       za_in[1] = '0;       za_in[2] = ONE_Q30;
               state_in = S_FRAME;
            end else begin
               state_in = S_NSHIFT;
            end
         end
         S_NSHIFT: begin
            // bring the largest magnitude to exactly 30 bits, one bit a cycle
            if (any_big) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (all_small) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               ctx_in   = C_SQ;
               term_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_SQRT: begin
            if (sub_ge) begin
               sx_in   = sub_d[63:0];
               root_in = (root_ff >> 1) + (64'd1 << {it_ff, 1'b0});
            end else begin
               root_in = root_ff >> 1;
            end
            if (it_ff == 5'd0) begin
               len_in   = root_in[30:0];
               comp_in  = 2'd0;
               state_in = S_DIV_INIT;
            end else begin
               it_in = it_ff - 5'd1;
            end
         end
         S_DIV_INIT: begin
            rem_in   = {1'b0, nfull[60:31]};
            num_in   = nfull[30:0];
            q_in     = '0;
            it_in    = 5'd30;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = sub_ge ? sub_d[30:0] : {rem_ff[29:0], num_ff[30]};
            num_in = {num_ff[29:0], 1'b0};
            q_in   = {q_ff[29:0], sub_ge};
            qv     = {1'b0, q_in};
            if (it_ff != 5'd0) begin
               it_in = it_ff - 5'd1;
            end else begin
               if (neg_ff[comp_ff]) qv = -qv;
               case (phase_ff)
                  PH_X:    xa_in[comp_ff] = qv;
                  PH_Y:    ya_in[comp_ff] = qv;
                  default: za_in[comp_ff] = qv;
               endcase
               if (comp_ff != 2'd2) begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_DIV_INIT;
               end else if (phase_ff == PH_Z) begin
                  state_in = S_FRAME;
               end else begin
                  phase_in = phase_ff + 2'd1;
                  state_in = S_LOAD;
               end
            end
         end
         S_FRAME: begin
            if (kind_ff == KIND_REF) begin
               rx_in = xa_ff;
               ry_in = ya_ff;
               rz_in = za_ff;
               for (int i = 0; i < 3; i++) org_in[i] = p_ff[i];
               ref_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ctx_in   = C_ROT;
               term_in  = 2'd0;
               res_in   = 4'd0;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               for (int i = 0; i < 9; i++) rsp_data_in[QW*i +: QW] = rot_ff[i];
               for (int i = 0; i < 3; i++) rsp_data_in[9*QW + CW*i +: CW] = sh_ff[i];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ref_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            rx_ff[i]  <= (i == 0) ? ONE_Q30 : '0;
            ry_ff[i]  <= (i == 1) ? ONE_Q30 : '0;
            rz_ff[i]  <= (i == 2) ? ONE_Q30 : '0;
            org_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ref_valid_ff <= ref_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         rz_ff  <= rz_in;
         org_ff <= org_in;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff   <= ctx_in;
      phase_ff <= phase_in;
      term_ff  <= term_in;
      res_ff   <= res_in;
      it_ff    <= it_in;
      comp_ff  <= comp_in;
      kind_ff  <= kind_in;
      p_ff     <= p_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      xa_ff    <= xa_in;
      ya_ff    <= ya_in;
      za_ff    <= za_in;
      prod_ff  <= mul_a * mul_b;
      if (state_ff == S_ACC) acc_ff <= acc_in;
      sx_ff    <= sx_in;
      root_ff  <= root_in;
      len_ff   <= len_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      q_ff     <= q_in;
      rot_ff   <= rot_in;
      sh_ff    <= sh_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // a response only appears out of the final hand-off state
   ap_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the hand-off state");

   // once a reference frame is stored it stays stored
   ap_ref_sticky: assert property (@(posedge clock) disable iff (reset)
      ref_valid_ff |=> ref_valid_ff)
      else $error("reference frame lost");

   // the first rotation entry (m_r0c0) is saturated to plus or minus one
   ap_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_data_ff[QW-1:0]) <= ONE_Q30
                        && $signed(rsp_data_ff[QW-1:0]) >= -ONE_Q30))
      else $error("rotation entry out of range");

   // a response cannot be dropped while it waits for the sink
   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending response changed");
`endif

endmodule

`default_nettype wire
